### rtl/core/dht_pkg.sv
// Shared types, codes and defaults for the DHT22 frame decoder and filter.
// No dependencies; the front, queue, back and top-level files import this package.
package dht_pkg;

	// Frame geometry
	localparam int FRAME_BITS = 40;
	localparam logic [5:0] FRAME_LAST_BIT = 6'd39;

	// Default depth of the queue between front and back
	localparam int DHT_QUEUE_DEPTH = 2;

	// Register reset values
	localparam logic [9:0]  BIT_THRESHOLD_RST     = 10'd64;
	localparam logic [14:0] PARSE_TEMP_LIMIT_RST  = 15'd800;
	localparam logic [15:0] HUM_LIMIT_RST         = 16'd1000;
	localparam logic [14:0] ACCEPT_TEMP_LIMIT_RST = 15'd600;
	localparam logic [14:0] MAX_TEMP_JUMP_RST     = 15'd30;
	localparam logic [15:0] MAX_HUM_JUMP_RST      = 16'd100;

	typedef enum logic [2:0] {
		REG_BIT_THRESHOLD     = 3'd0,
		REG_PARSE_TEMP_LIMIT  = 3'd1,
		REG_HUM_LIMIT         = 3'd2,
		REG_ACCEPT_TEMP_LIMIT = 3'd3,
		REG_MAX_TEMP_JUMP     = 3'd4,
		REG_MAX_HUM_JUMP      = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_START     = 2'd0,
		OP_BIT       = 2'd1,
		OP_HANDSHAKE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_HANDSHAKE1  = 3'd1,
		ST_HANDSHAKE2  = 3'd2,
		ST_HANDSHAKE3  = 3'd3,
		ST_BIT_TIMEOUT = 3'd4,
		ST_CHECKSUM    = 3'd5,
		ST_FILTER      = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MODE_AS_IS = 2'd0,
		MODE_RIGHT = 2'd1,
		MODE_LEFT  = 2'd2
	} mode_t;

	// Command kinds handed from front to back
	typedef enum logic [1:0] {
		CMD_HANDSHAKE   = 2'd0,
		CMD_BIT_TIMEOUT = 2'd1,
		CMD_FRAME       = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [1:0]             stage;
		logic [FRAME_BITS-1:0]  frame;
	} cmd_t;

	// Configuration register file
	typedef struct packed {
		logic [9:0]  bit_threshold_us;
		logic [14:0] parse_temp_limit;
		logic [15:0] hum_limit;
		logic [14:0] accept_temp_limit;
		logic [14:0] max_temp_jump;
		logic [15:0] max_hum_jump;
	} cfg_t;

endpackage

### rtl/core/dht_ifs.sv
// Valid/ready channel interfaces for the decoder input and result words.
// Depends on nothing.
interface dht_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [13:0] pulse_width_us;
	logic [1:0]  handshake_stage;

	modport source (output valid, op, pulse_width_us, handshake_stage, input ready);
	modport sink   (input valid, op, pulse_width_us, handshake_stage, output ready);
endinterface

interface dht_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  align_mode;
	logic [14:0] temp_tenths;
	logic [15:0] hum_tenths;
	logic [7:0]  frame_checksum;

	modport source (output valid, status, align_mode, temp_tenths, hum_tenths,
		frame_checksum, input ready);
	modport sink   (input valid, status, align_mode, temp_tenths, hum_tenths,
		frame_checksum, output ready);
endinterface

### rtl/core/dht_front.sv
// Front end: accepts input words, assembles the 40-bit frame and issues
// commands for the back end. Depends on dht_pkg and dht_in_if.
module dht_front
	import dht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	dht_in_if.sink      in_ch,
	input  logic [9:0]  bit_threshold_us,
	output logic        push_valid,
	input  logic        push_ready,
	output cmd_t        push_cmd
);

	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic [5:0]            cnt_q, cnt_d;
	logic                  active_q, active_d;
	logic                  accept;
	logic                  bit_val;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign bit_val     = in_ch.pulse_width_us > {4'd0, bit_threshold_us};

	// Classify the word and step the frame assembly
	always_comb begin
		frame_d        = frame_q;
		cnt_d          = cnt_q;
		active_d       = active_q;
		push_valid     = 1'b0;
		push_cmd.kind  = CMD_HANDSHAKE;
		push_cmd.stage = in_ch.handshake_stage;
		push_cmd.frame = {frame_q[FRAME_BITS-2:0], bit_val};
		if (accept) begin
			case (op_t'(in_ch.op))
				OP_START: begin
					frame_d  = '0;
					cnt_d    = '0;
					active_d = 1'b1;
				end
				OP_HANDSHAKE: begin
					active_d   = 1'b0;
					cnt_d      = '0;
					push_valid = 1'b1;
					// stage zero reports as the first stage
					if (in_ch.handshake_stage == 2'd0)
						push_cmd.stage = 2'd1;
				end
				OP_BIT: begin
					if (active_q) begin
						if (in_ch.pulse_width_us == '0 && cnt_q != FRAME_LAST_BIT) begin
							active_d      = 1'b0;
							cnt_d         = '0;
							push_valid    = 1'b1;
							push_cmd.kind = CMD_BIT_TIMEOUT;
						end else if (cnt_q == FRAME_LAST_BIT) begin
							active_d      = 1'b0;
							cnt_d         = '0;
							frame_d       = push_cmd.frame;
							push_valid    = 1'b1;
							push_cmd.kind = CMD_FRAME;
						end else begin
							frame_d = {frame_q[FRAME_BITS-2:0], bit_val};
							cnt_d   = cnt_q + 6'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
		end else begin
			frame_q  <= frame_d;
			cnt_q    <= cnt_d;
			active_q <= active_d;
		end
	end

endmodule

### rtl/core/dht_queue.sv
// Short command queue between front and back end.
// Depends on dht_pkg for the command type.
module dht_queue
	import dht_pkg::*;
#(
	parameter int DEPTH = DHT_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> count_q == CW'(DEPTH) || $past(pop))
		else $error("queue refused a push while not full");

endmodule

### rtl/core/dht_back.sv
// Back end: tries the three frame alignments, then applies the range and
// jump filter against the last valid reading and holds the result word.
// Depends on dht_pkg and dht_out_if.
module dht_back
	import dht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  cmd_t     cmd,
	dht_out_if.source out_ch
);

	typedef struct packed {
		logic        pass;
		logic [14:0] temp;
		logic [15:0] hum;
		logic [7:0]  cs;
	} cand_t;

	// Checksum and range check of one alignment
	function automatic cand_t eval_cand(input logic [FRAME_BITS-1:0] f,
		input logic [14:0] plim, input logic [15:0] hlim);
		cand_t       r;
		logic [15:0] raw;
		r.cs   = f[39:32] + f[31:24] + f[23:16] + f[15:8];
		r.hum  = f[39:24];
		raw    = f[23:8];
		r.temp = raw[15] ? 15'd0 : raw[14:0];
		r.pass = (r.cs == f[7:0]) && (r.hum <= hlim) && (r.temp <= plim);
		return r;
	endfunction

	function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Stage 1 registers: chosen candidate
	logic        valid_s1;
	cmd_kind_t   kind_s1;
	logic [1:0]  stage_s1;
	logic        found_s1;
	mode_t       mode_s1;
	logic [14:0] temp_s1;
	logic [15:0] hum_s1;
	logic [7:0]  cs_s1;

	// Output and filter state
	logic        out_valid_q;
	status_t     status_q;
	mode_t       mode_q;
	logic [14:0] temp_q;
	logic [15:0] hum_q;
	logic [7:0]  cs_q;
	logic [14:0] last_temp_q;
	logic [15:0] last_hum_q;
	logic        have_valid_q;

	cand_t c0, c1, c2;
	logic  adv, take;
	logic  filt_ok;

	assign adv       = valid_s1 && (!out_valid_q || out_ch.ready);
	assign take      = cmd_valid && (!valid_s1 || adv);
	assign cmd_ready = !valid_s1 || adv;

	assign c0 = eval_cand(cmd.frame, cfg.parse_temp_limit, cfg.hum_limit);
	assign c1 = eval_cand({1'b0, cmd.frame[FRAME_BITS-1:1]}, cfg.parse_temp_limit,
		cfg.hum_limit);
	assign c2 = eval_cand({cmd.frame[FRAME_BITS-2:0], 1'b0}, cfg.parse_temp_limit,
		cfg.hum_limit);

	// Stage 1: pick the first alignment that passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take || adv)
			valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= cmd.kind;
			stage_s1 <= cmd.stage;
			found_s1 <= c0.pass || c1.pass || c2.pass;
			if (c0.pass) begin
				mode_s1 <= MODE_AS_IS;
				temp_s1 <= c0.temp;
				hum_s1  <= c0.hum;
				cs_s1   <= c0.cs;
			end else if (c1.pass) begin
				mode_s1 <= MODE_RIGHT;
				temp_s1 <= c1.temp;
				hum_s1  <= c1.hum;
				cs_s1   <= c1.cs;
			end else if (c2.pass) begin
				mode_s1 <= MODE_LEFT;
				temp_s1 <= c2.temp;
				hum_s1  <= c2.hum;
				cs_s1   <= c2.cs;
			end else begin
				// no alignment passed: report the sum as received
				mode_s1 <= MODE_AS_IS;
				temp_s1 <= c0.temp;
				hum_s1  <= c0.hum;
				cs_s1   <= c0.cs;
			end
		end
	end

	// Plausibility and jump check against the last valid reading
	always_comb begin
		filt_ok = (temp_s1 <= cfg.accept_temp_limit) && (hum_s1 <= cfg.hum_limit);
		if (have_valid_q)
			filt_ok = filt_ok
				&& (abs_diff({1'b0, temp_s1}, {1'b0, last_temp_q}) <= {1'b0, cfg.max_temp_jump})
				&& (abs_diff(hum_s1, last_hum_q) <= cfg.max_hum_jump);
	end

	// Stage 2: result word and last valid reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			last_temp_q  <= '0;
			last_hum_q   <= '0;
			have_valid_q <= 1'b0;
		end else begin
			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			if (adv && kind_s1 == CMD_FRAME && found_s1 && filt_ok) begin
				last_temp_q  <= temp_s1;
				last_hum_q   <= hum_s1;
				have_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_q <= MODE_AS_IS;
			temp_q <= last_temp_q;
			hum_q  <= last_hum_q;
			cs_q   <= '0;
			case (kind_s1)
				CMD_HANDSHAKE:   status_q <= status_t'({1'b0, stage_s1});
				CMD_BIT_TIMEOUT: status_q <= ST_BIT_TIMEOUT;
				CMD_FRAME: begin
					cs_q <= cs_s1;
					if (!found_s1) begin
						status_q <= ST_CHECKSUM;
					end else if (filt_ok) begin
						status_q <= ST_OK;
						mode_q   <= mode_s1;
						temp_q   <= temp_s1;
						hum_q    <= hum_s1;
					end else begin
						status_q <= ST_FILTER;
						mode_q   <= mode_s1;
					end
				end
				default: status_q <= ST_BIT_TIMEOUT;
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.align_mode     = mode_q;
	assign out_ch.temp_tenths    = temp_q;
	assign out_ch.hum_tenths     = hum_q;
	assign out_ch.frame_checksum = cs_q;

	a_ok_has_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OK |-> have_valid_q)
		else $error("ok word without a valid reading stored");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(kind_s1) && $stable(cs_s1))
		else $error("stage 1 lost its word while stalled");

endmodule

### rtl/core/dht22_frame_decoder_filter.sv
// DHT22 frame decoder and filter, top level. Depends on dht_pkg, dht_ifs,
// dht_front, dht_queue and dht_back.
// Throughput: one input word per cycle while the queue has room; the filter feedback never stalls.
// A word that ends or aborts a frame passes the queue, stage 1 and the output register in turn.
// Reset: asynchronous and active low; frame, last valid reading and queue clear at once and
// the registers return to their defaults; there is no clearing pass.
module dht22_frame_decoder_filter
	import dht_pkg::*;
#(
	parameter int QUEUE_DEPTH = DHT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	dht_in_if.sink      in_ch,
	dht_out_if.source   out_ch,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);

	cfg_t cfg_q;
	logic push_valid, push_ready, pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_threshold_us  <= BIT_THRESHOLD_RST;
			cfg_q.parse_temp_limit  <= PARSE_TEMP_LIMIT_RST;
			cfg_q.hum_limit         <= HUM_LIMIT_RST;
			cfg_q.accept_temp_limit <= ACCEPT_TEMP_LIMIT_RST;
			cfg_q.max_temp_jump     <= MAX_TEMP_JUMP_RST;
			cfg_q.max_hum_jump      <= MAX_HUM_JUMP_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_BIT_THRESHOLD:     cfg_q.bit_threshold_us  <= wr_data[9:0];
				REG_PARSE_TEMP_LIMIT:  cfg_q.parse_temp_limit  <= wr_data[14:0];
				REG_HUM_LIMIT:         cfg_q.hum_limit         <= wr_data;
				REG_ACCEPT_TEMP_LIMIT: cfg_q.accept_temp_limit <= wr_data[14:0];
				REG_MAX_TEMP_JUMP:     cfg_q.max_temp_jump     <= wr_data[14:0];
				REG_MAX_HUM_JUMP:      cfg_q.max_hum_jump      <= wr_data;
				default: ;
			endcase
		end
	end

	dht_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.bit_threshold_us (cfg_q.bit_threshold_us),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_cmd         (push_cmd)
	);

	dht_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	dht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.out_ch    (out_ch)
	);

endmodule
